FILE: sv/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared types and constants of the cassette byte pulse encoder.
// ----------------------------------------------------------------------------
package cbpe_pkg;

    // Timing base
    localparam int CLOCK_HZ   = 1000000;
    localparam int SHORT_HALF = 208;       // long half is twice this
    localparam int FRAME_LEN  = 14;
    localparam int HALF_NUM   = 2 * FRAME_LEN;

    // Widths
    localparam int RATE_W   = 18;
    localparam int AMP_W    = 15;
    localparam int DATA_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int CARRY_W  = $clog2(CLOCK_HZ);
    localparam int PROD_W   = $clog2(SHORT_HALF * ((1 << RATE_W) - 1) + 1);
    localparam int Q_W      = COUNT_W + 1;   // saturated quotient, 0..2^COUNT_W
    localparam int HALF_W   = $clog2(HALF_NUM);
    localparam int CFG_W    = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [HALF_W-1:0]  HALF_LAST = HALF_W'(HALF_NUM - 1);

    typedef logic [FRAME_LEN-1:0] t_frame;

    // Register indexes
    typedef enum logic [CFG_W-1:0] {
        CFG_SAMPLE_RATE = 2'd0,
        CFG_AMPLITUDE   = 2'd1
    } t_cfg_index;

    // Rate divider sequencer
    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_RECIP,
        DIV_REM,
        DIV_FIN
    } t_div_state;

    // Per-rate timing: whole samples and remainder for both half lengths
    typedef struct packed {
        logic               busy;
        logic [Q_W-1:0]     q_short;
        logic [CARRY_W-1:0] r_short;
        logic [Q_W-1:0]     q_long;
        logic [CARRY_W-1:0] r_long;
    } t_timing;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

FILE: sv/cbpe_in_if.sv
// ----------------------------------------------------------------------------
// cbpe_in_if
// Input channel: one data byte per transfer.
// ----------------------------------------------------------------------------
interface cbpe_in_if;
    logic                         valid;
    logic                         ready;
    logic [cbpe_pkg::DATA_W-1:0]  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: sv/cbpe_out_if.sv
// ----------------------------------------------------------------------------
// cbpe_out_if
// Output channel: one half-pulse per transfer.
// ----------------------------------------------------------------------------
interface cbpe_out_if;
    logic                                valid;
    logic                                ready;
    logic                                half_level;
    logic signed [cbpe_pkg::SAMPLE_W-1:0] sample_value;
    logic [cbpe_pkg::COUNT_W-1:0]        sample_count;
    logic                                last_half;

    modport source (output valid, output half_level, output sample_value,
                    output sample_count, output last_half, input ready);
    modport sink   (input valid, input half_level, input sample_value,
                    input sample_count, input last_half, output ready);
endinterface

FILE: sv/cbpe_rate_div.sv
// ----------------------------------------------------------------------------
// cbpe_rate_div
// Converts the sample rate into samples and remainder per half-pulse length
// by reciprocal multiplication: multiply, reciprocal, remainder, finish. Runs
// after reset and after each rate write.
// ----------------------------------------------------------------------------
module cbpe_rate_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic [cbpe_pkg::RATE_W-1:0]   i_rate,
    output cbpe_pkg::t_timing             o_timing
);

    // Reciprocal of the clock rate, exact for every product below 2^PROD_W
    localparam int RECIP_SH = cbpe_pkg::PROD_W + cbpe_pkg::CARRY_W;
    localparam int RECIP_W  = cbpe_pkg::PROD_W + 2;
    localparam int WIDE_W   = cbpe_pkg::PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(cbpe_pkg::CLOCK_HZ) - 64'd1)
                 / 64'(cbpe_pkg::CLOCK_HZ));
    localparam logic [cbpe_pkg::CARRY_W:0] DIVISOR =
        (cbpe_pkg::CARRY_W + 1)'(cbpe_pkg::CLOCK_HZ);
    localparam logic [cbpe_pkg::PROD_W-1:0] DIVISOR_P =
        cbpe_pkg::PROD_W'(cbpe_pkg::CLOCK_HZ);

    cbpe_pkg::t_div_state r_state, n_state;

    logic [cbpe_pkg::PROD_W-1:0]  r_prod;
    logic [cbpe_pkg::PROD_W-1:0]  r_quo;
    logic [cbpe_pkg::CARRY_W-1:0] r_rem;

    logic [cbpe_pkg::Q_W-1:0]     r_q_short, r_q_long;
    logic [cbpe_pkg::CARRY_W-1:0] r_r_short, r_r_long;

    logic [WIDE_W-1:0]            recip_prod;
    logic [cbpe_pkg::PROD_W-1:0]  quo_scaled;
    logic [cbpe_pkg::CARRY_W:0]   rem_dbl;
    logic                         dbl_ge;
    logic [cbpe_pkg::PROD_W:0]    quo_long;
    logic                         busy;

    // Clamp a quotient to one above the largest count
    function automatic logic [cbpe_pkg::Q_W-1:0] sat_q(input logic [cbpe_pkg::PROD_W:0] q);
        logic [cbpe_pkg::Q_W-1:0] res;
        if (q > (cbpe_pkg::PROD_W + 1)'(cbpe_pkg::COUNT_MAX))
            res = cbpe_pkg::Q_W'({1'b0, cbpe_pkg::COUNT_MAX}) + 1'b1;
        else
            res = q[cbpe_pkg::Q_W-1:0];
        return res;
    endfunction

    // Reciprocal product, remainder and long-half derivation
    always_comb begin
        recip_prod = WIDE_W'(r_prod) * WIDE_W'(RECIP);
        quo_scaled = r_quo * DIVISOR_P;
        rem_dbl    = {r_rem, 1'b0};
        dbl_ge     = (rem_dbl >= DIVISOR);
        quo_long   = {r_quo, dbl_ge};
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbpe_pkg::DIV_MUL;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and status
    always_comb begin
        n_state = r_state;
        busy    = 1'b1;
        unique case (r_state)
            cbpe_pkg::DIV_IDLE: begin
                busy = 1'b0;
            end
            cbpe_pkg::DIV_MUL: begin
                n_state = cbpe_pkg::DIV_RECIP;
            end
            cbpe_pkg::DIV_RECIP: begin
                n_state = cbpe_pkg::DIV_REM;
            end
            cbpe_pkg::DIV_REM: begin
                n_state = cbpe_pkg::DIV_FIN;
            end
            cbpe_pkg::DIV_FIN: begin
                n_state = cbpe_pkg::DIV_IDLE;
            end
            default: begin
                n_state = cbpe_pkg::DIV_MUL;
            end
        endcase
        if (i_restart)
            n_state = cbpe_pkg::DIV_MUL;
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cbpe_pkg::DIV_MUL: begin
                r_prod <= cbpe_pkg::PROD_W'(i_rate) *
                          cbpe_pkg::PROD_W'(cbpe_pkg::SHORT_HALF);
            end
            cbpe_pkg::DIV_RECIP: begin
                r_quo <= cbpe_pkg::PROD_W'(recip_prod >> RECIP_SH);
            end
            cbpe_pkg::DIV_REM: begin
                r_rem <= cbpe_pkg::CARRY_W'(r_prod - quo_scaled);
            end
            cbpe_pkg::DIV_FIN: begin
                r_q_short <= sat_q({1'b0, r_quo});
                r_r_short <= r_rem;
                r_q_long  <= sat_q(quo_long);
                r_r_long  <= dbl_ge ? cbpe_pkg::CARRY_W'(rem_dbl - DIVISOR)
                                    : cbpe_pkg::CARRY_W'(rem_dbl);
            end
            default: begin
            end
        endcase
    end

    assign o_timing.busy    = busy;
    assign o_timing.q_short = r_q_short;
    assign o_timing.r_short = r_r_short;
    assign o_timing.q_long  = r_q_long;
    assign o_timing.r_long  = r_r_long;

endmodule

FILE: sv/cbpe_front.sv
// ----------------------------------------------------------------------------
// cbpe_front
// Accepts data bytes and builds the 14-bit frame: start, data, parity, stops.
// ----------------------------------------------------------------------------
module cbpe_front (
    cbpe_in_if.sink              i_in,
    input  logic                 i_cfg_we,
    input  logic                 i_busy,
    input  cbpe_pkg::t_fifo_status i_fifo,
    output logic                 o_push,
    output cbpe_pkg::t_frame     o_frame
);

    localparam cbpe_pkg::t_frame DATA_MASK = 14'h01FE;
    localparam cbpe_pkg::t_frame STOP_BITS = 14'h3C00;
    localparam int PARITY_POS = cbpe_pkg::DATA_W + 1;

    logic parity;

    // Hold off while the queue is full, a configuration write is present or the rate timing is being rebuilt
    assign i_in.ready = !i_fifo.full && !i_busy && !i_cfg_we;
    assign o_push     = i_in.valid && i_in.ready;

    // Frame assembly, LSB sent first
    always_comb begin
        parity  = ^i_in.data_byte;
        o_frame = (cbpe_pkg::t_frame'({i_in.data_byte, 1'b0}) & DATA_MASK)
                | (cbpe_pkg::t_frame'(parity) << PARITY_POS)
                | STOP_BITS;
    end

endmodule

FILE: sv/cbpe_fifo.sv
// ----------------------------------------------------------------------------
// cbpe_fifo
// Two-entry frame queue between the front and the back.
// ----------------------------------------------------------------------------
module cbpe_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  cbpe_pkg::t_frame       i_frame,
    input  logic                   i_pop,
    output cbpe_pkg::t_frame       o_head,
    output cbpe_pkg::t_fifo_status o_status
);

    cbpe_pkg::t_frame r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)
                r_rd_ptr <= ~r_rd_ptr;
            priority if (i_push && !i_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push)
                r_cnt <= r_cnt - 1'b1;
            else
                r_cnt <= r_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_frame;
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = r_cnt[1];
    assign o_status.empty = (r_cnt == 2'd0);

endmodule

FILE: sv/cbpe_back.sv
// ----------------------------------------------------------------------------
// cbpe_back
// Walks the 28 half-pulses of the head frame, one per cycle while the output
// is taken, chaining the fractional sample carry, into a registered output stage.
// ----------------------------------------------------------------------------
module cbpe_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cbpe_pkg::t_timing           i_timing,
    input  logic [cbpe_pkg::AMP_W-1:0]  i_amplitude,
    input  cbpe_pkg::t_frame            i_head,
    input  cbpe_pkg::t_fifo_status      i_fifo,
    output logic                        o_pop,
    cbpe_out_if.source                  o_out
);

    localparam logic [cbpe_pkg::CARRY_W:0] MODULUS =
        (cbpe_pkg::CARRY_W + 1)'(cbpe_pkg::CLOCK_HZ);

    logic [cbpe_pkg::HALF_W-1:0]  r_half;
    logic [cbpe_pkg::CARRY_W-1:0] r_carry, n_carry;

    logic                         r_ov;
    logic                         r_level;
    logic [cbpe_pkg::SAMPLE_W-1:0] r_value;
    logic [cbpe_pkg::COUNT_W-1:0] r_count;
    logic                         r_last;

    logic                         fire;
    logic                         level;
    logic                         is_long;
    logic [cbpe_pkg::Q_W-1:0]     q_sel, q_full;
    logic [cbpe_pkg::CARRY_W-1:0] r_sel;
    logic [cbpe_pkg::CARRY_W:0]   sum;
    logic                         wrap;
    logic [cbpe_pkg::COUNT_W-1:0] count;
    logic [cbpe_pkg::SAMPLE_W-1:0] amp_ext, value;
    logic                         last;

    // Issue when a frame is waiting and the output slot frees up
    assign fire  = !i_fifo.empty && (!r_ov || o_out.ready);
    assign o_pop = fire && (r_half == cbpe_pkg::HALF_LAST);

    // Sample count, level and value for this half
    always_comb begin
        level   = r_half[0];
        is_long = level && !i_head[r_half[cbpe_pkg::HALF_W-1:1]];
        q_sel   = is_long ? i_timing.q_long : i_timing.q_short;
        r_sel   = is_long ? i_timing.r_long : i_timing.r_short;
        sum     = {1'b0, r_sel} + {1'b0, r_carry};
        wrap    = (sum >= MODULUS);
        n_carry = wrap ? cbpe_pkg::CARRY_W'(sum - MODULUS) : cbpe_pkg::CARRY_W'(sum);
        q_full  = q_sel + cbpe_pkg::Q_W'(wrap);
        count   = (q_full > cbpe_pkg::Q_W'(cbpe_pkg::COUNT_MAX))
                  ? cbpe_pkg::COUNT_MAX : q_full[cbpe_pkg::COUNT_W-1:0];
        amp_ext = cbpe_pkg::SAMPLE_W'(i_amplitude);
        value   = level ? amp_ext : (cbpe_pkg::SAMPLE_W'(0) - amp_ext);
        last    = (r_half == cbpe_pkg::HALF_LAST);
    end

    // Sequencer and carry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= '0;
            r_carry <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (fire) begin
                r_half  <= last ? '0 : r_half + 1'b1;
                r_carry <= n_carry;
                r_ov    <= 1'b1;
            end else if (o_out.ready) begin
                r_ov    <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_level <= level;
            r_value <= value;
            r_count <= count;
            r_last  <= last;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.half_level   = r_level;
    assign o_out.sample_value = $signed(r_value);
    assign o_out.sample_count = r_count;
    assign o_out.last_half    = r_last;

endmodule

FILE: sv/cassette_byte_pulse_encoder_core.sv
// ----------------------------------------------------------------------------
// cassette_byte_pulse_encoder_core
// Throughput: one half-pulse per cycle while the output is taken, set by the
//   back sequencer chaining the sample carry; 28 per byte, bytes queue two deep.
// Order: a byte goes into the queue, then its first half is registered for output.
// Reset: registers return to 44100 Hz / 16000, carry clears; the rate divider
//   then runs mul, recip, rem, fin (also after each sample_rate write), input held.
// ----------------------------------------------------------------------------
module cassette_byte_pulse_encoder_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cbpe_pkg::CFG_W-1:0]   i_cfg_index,
    input  logic [cbpe_pkg::RATE_W-1:0]  i_cfg_data,
    cbpe_in_if.sink                      i_in,
    cbpe_out_if.source                   o_out
);

    logic [cbpe_pkg::RATE_W-1:0] r_sample_rate;
    logic [cbpe_pkg::AMP_W-1:0]  r_amplitude;

    cbpe_pkg::t_timing      timing;
    cbpe_pkg::t_fifo_status fifo_st;
    cbpe_pkg::t_frame       push_frame;
    cbpe_pkg::t_frame       head_frame;
    logic                   push;
    logic                   pop;
    logic                   rate_wr;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= cbpe_pkg::RATE_W'(44100);
            r_amplitude   <= cbpe_pkg::AMP_W'(16000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cbpe_pkg::CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data;
                cbpe_pkg::CFG_AMPLITUDE:   r_amplitude <= i_cfg_data[cbpe_pkg::AMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign rate_wr = i_cfg_we && (i_cfg_index == cbpe_pkg::CFG_SAMPLE_RATE);

    cbpe_rate_div u_rate_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (rate_wr),
        .i_rate    (r_sample_rate),
        .o_timing  (timing)
    );

    cbpe_front u_front (
        .i_in     (i_in),
        .i_cfg_we (i_cfg_we),
        .i_busy   (timing.busy),
        .i_fifo   (fifo_st),
        .o_push   (push),
        .o_frame  (push_frame)
    );

    cbpe_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_frame  (push_frame),
        .i_pop    (pop),
        .o_head   (head_frame),
        .o_status (fifo_st)
    );

    cbpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_timing    (timing),
        .i_amplitude (r_amplitude),
        .i_head      (head_frame),
        .i_fifo      (fifo_st),
        .o_pop       (pop),
        .o_out       (o_out)
    );

    // Assertions
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !timing.busy)
        else $error("byte accepted while rate timing rebuilt");

    a_fifo_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_st.full && fifo_st.empty))
        else $error("queue reports full and empty");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!timing.busy && !$past(timing.busy)) |->
        (timing.r_short < cbpe_pkg::CARRY_W'(cbpe_pkg::CLOCK_HZ)) &&
        (timing.r_long < cbpe_pkg::CARRY_W'(cbpe_pkg::CLOCK_HZ)))
        else $error("remainder out of range");

    a_last_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_half) |-> o_out.half_level)
        else $error("last half-pulse is not a high half");

endmodule
